FILE: src/ttr_pkg.sv
`timescale 1ns / 1ps

package ttr_pkg;

    localparam int MAX_SIDE   = 16384;
    localparam int SIDE_W     = 15;
    localparam int BLK_W      = 5;
    localparam int STEPS_W    = 4;
    localparam int DIV_STEPS  = SIDE_W;
    localparam int SIDE_LIMIT = (1 << SIDE_W) - 1;

    typedef enum logic [2:0] {
        REG_DOWNSCALE = 3'd0,
        REG_MIN_RES   = 3'd1,
        REG_MAX_RES   = 3'd2,
        REG_VOLUME    = 3'd3,
        REG_ALIGN     = 3'd4,
        REG_BLOCK_W   = 3'd5,
        REG_BLOCK_H   = 3'd6,
        REG_SPARE     = 3'd7
    } t_reg_index;

    typedef struct packed {
        logic [SIDE_W-1:0] ow;
        logic [SIDE_W-1:0] oh;
        logic [SIDE_W-1:0] w;
        logic [SIDE_W-1:0] h;
        logic              derr;
    } t_ctx;

    typedef struct packed {
        logic [SIDE_W-1:0] rem;
        logic [SIDE_W-1:0] sh;
    } t_dstep;

    function automatic t_dstep div_step(t_dstep s, logic [SIDE_W-1:0] d);
        logic [SIDE_W:0] t;
        logic            qb;
        t_dstep          r;
        t  = {s.rem, s.sh[SIDE_W-1]};
        qb = (t >= {1'b0, d});
        if (qb) begin
            r.rem = SIDE_W'(t - {1'b0, d});
        end else begin
            r.rem = t[SIDE_W-1:0];
        end
        r.sh = {s.sh[SIDE_W-2:0], qb};
        return r;
    endfunction

endpackage

FILE: src/ttr_div.sv
`timescale 1ns / 1ps

module ttr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [2*ttr_pkg::SIDE_W-1:0]  i_dividend,
    input  logic [ttr_pkg::SIDE_W-1:0]    i_divisor,
    input  ttr_pkg::t_ctx                 i_ctx,
    output logic                          o_valid,
    output logic [ttr_pkg::SIDE_W-1:0]    o_quot,
    output logic [ttr_pkg::SIDE_W-1:0]    o_rem,
    output ttr_pkg::t_ctx                 o_ctx
);
    import ttr_pkg::*;

    // restoring division, one quotient bit per stage
    logic              r_v   [1:DIV_STEPS];
    t_dstep            r_st  [1:DIV_STEPS];
    logic [SIDE_W-1:0] r_div [1:DIV_STEPS];
    t_ctx              r_ctx [1:DIV_STEPS];
    t_dstep            n_st  [1:DIV_STEPS];
    t_dstep            s_in;

    always_comb begin
        s_in.rem = i_dividend[2*SIDE_W-1:SIDE_W];
        s_in.sh  = i_dividend[SIDE_W-1:0];
        n_st[1]  = div_step(s_in, i_divisor);
        for (int k = 2; k <= DIV_STEPS; k++) begin
            n_st[k] = div_step(r_st[k-1], r_div[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[1]  <= n_st[1];
        r_div[1] <= i_divisor;
        r_ctx[1] <= i_ctx;
        for (int k = 2; k <= DIV_STEPS; k++) begin
            r_st[k]  <= n_st[k];
            r_div[k] <= r_div[k-1];
            r_ctx[k] <= r_ctx[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            r_v[1] <= i_valid;
            for (int k = 2; k <= DIV_STEPS; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS];
    assign o_quot  = r_st[DIV_STEPS].sh;
    assign o_rem   = r_st[DIV_STEPS].rem;
    assign o_ctx   = r_ctx[DIV_STEPS];

endmodule

FILE: src/texture_target_resolution.sv
`timescale 1ns / 1ps

// Texture target size unit. A request is taken on every cycle where i_start is
// high (o_busy is always low) and its result appears on the o_done strobe, one
// result per request in request order. Each result passes four 15-stage
// restoring dividers in series (aspect, scale factor, volume width, block
// alignment) plus four ordinary stages. The receiver cannot stall: results
// must be captured on the strobe cycle. Configuration writes take effect at once
// and are meant to be done while no request is in flight.
module texture_target_resolution (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [ttr_pkg::SIDE_W-1:0] i_orig_width,
    input  logic [ttr_pkg::SIDE_W-1:0] i_orig_height,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_index,
    input  logic [ttr_pkg::SIDE_W-1:0] i_cfg_wdata,
    output logic                       o_done,
    output logic [ttr_pkg::SIDE_W-1:0] o_target_width,
    output logic [ttr_pkg::SIDE_W-1:0] o_target_height,
    output logic                       o_adjusted,
    output logic                       o_divide_error
);
    import ttr_pkg::*;

    localparam int LATENCY = 4 + 4 * DIV_STEPS;

    logic [STEPS_W-1:0] r_steps;
    logic [SIDE_W-1:0]  r_min;
    logic [SIDE_W-1:0]  r_max;
    logic               r_volume;
    logic               r_align;
    logic [BLK_W-1:0]   r_bw;
    logic [BLK_W-1:0]   r_bh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps  <= '0;
            r_min    <= SIDE_W'(1);
            r_max    <= SIDE_W'(MAX_SIDE);
            r_volume <= 1'b0;
            r_align  <= 1'b0;
            r_bw     <= BLK_W'(4);
            r_bh     <= BLK_W'(4);
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_DOWNSCALE: r_steps  <= i_cfg_wdata[STEPS_W-1:0];
                REG_MIN_RES:   r_min    <= i_cfg_wdata;
                REG_MAX_RES:   r_max    <= i_cfg_wdata;
                REG_VOLUME:    r_volume <= i_cfg_wdata[0];
                REG_ALIGN:     r_align  <= i_cfg_wdata[0];
                REG_BLOCK_W:   r_bw     <= i_cfg_wdata[BLK_W-1:0];
                REG_BLOCK_H:   r_bh     <= i_cfg_wdata[BLK_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    function automatic logic [SIDE_W-1:0] clamp_side(logic [SIDE_W-1:0] v,
                                                     logic [SIDE_W-1:0] lo,
                                                     logic [SIDE_W-1:0] hi);
        logic [SIDE_W-1:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // stage 1: shift and clamp
    logic  r1_v;
    t_ctx  r1_ctx;
    t_ctx  n1_ctx;

    always_comb begin
        n1_ctx.ow   = i_orig_width;
        n1_ctx.oh   = i_orig_height;
        n1_ctx.w    = clamp_side(i_orig_width >> r_steps, r_min, r_max);
        n1_ctx.h    = clamp_side(i_orig_height >> r_steps, r_min, r_max);
        n1_ctx.derr = 1'b0;
    end

    // stage 2: aspect product
    logic                  r2_v;
    t_ctx                  r2_ctx;
    logic [2*SIDE_W-1:0]   r2_prod;
    logic [SIDE_W-1:0]     r2_dsr;

    always_ff @(posedge i_clk) begin
        r1_ctx <= n1_ctx;
        r2_ctx <= r1_ctx;
        if (r1_ctx.ow > r1_ctx.oh) begin
            r2_prod <= r1_ctx.w * r1_ctx.oh;
            r2_dsr  <= r1_ctx.ow;
        end else begin
            r2_prod <= r1_ctx.h * r1_ctx.ow;
            r2_dsr  <= r1_ctx.oh;
        end
    end

    logic              d1_v;
    logic [SIDE_W-1:0] d1_q;
    logic [SIDE_W-1:0] d1_r;
    t_ctx              d1_ctx;

    ttr_div u_div_aspect (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r2_v),
        .i_dividend (r2_prod),
        .i_divisor  (r2_dsr),
        .i_ctx      (r2_ctx),
        .o_valid    (d1_v),
        .o_quot     (d1_q),
        .o_rem      (d1_r),
        .o_ctx      (d1_ctx)
    );

    // stage 3: apply aspect result
    logic r3_v;
    t_ctx r3_ctx;
    t_ctx n3_ctx;

    always_comb begin
        n3_ctx = d1_ctx;
        if (d1_ctx.ow > d1_ctx.oh) begin
            n3_ctx.h = d1_q;
        end else if (d1_ctx.ow < d1_ctx.oh) begin
            n3_ctx.w = d1_q;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_ctx <= n3_ctx;
    end

    logic              d2_v;
    logic [SIDE_W-1:0] d2_q;
    logic [SIDE_W-1:0] d2_r;
    t_ctx              d2_ctx;

    ttr_div u_div_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r3_v),
        .i_dividend ({{SIDE_W{1'b0}}, r3_ctx.oh}),
        .i_divisor  (r3_ctx.h),
        .i_ctx      (r3_ctx),
        .o_valid    (d2_v),
        .o_quot     (d2_q),
        .o_rem      (d2_r),
        .o_ctx      (d2_ctx)
    );

    t_ctx c2_ctx;

    always_comb begin
        c2_ctx      = d2_ctx;
        c2_ctx.derr = r_volume && ((d2_ctx.h == '0) || (d2_q == '0));
    end

    logic              d3_v;
    logic [SIDE_W-1:0] d3_q;
    logic [SIDE_W-1:0] d3_r;
    t_ctx              d3_ctx;

    ttr_div u_div_volume (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (d2_v),
        .i_dividend ({{SIDE_W{1'b0}}, d2_ctx.ow}),
        .i_divisor  (d2_q),
        .i_ctx      (c2_ctx),
        .o_valid    (d3_v),
        .o_quot     (d3_q),
        .o_rem      (d3_r),
        .o_ctx      (d3_ctx)
    );

    t_ctx c3_ctx;

    always_comb begin
        c3_ctx = d3_ctx;
        if (r_volume && !d3_ctx.derr) begin
            c3_ctx.w = d3_q;
        end
    end

    logic              da_v;
    logic [SIDE_W-1:0] da_q;
    logic [SIDE_W-1:0] da_r;
    t_ctx              da_ctx;
    logic              db_v;
    logic [SIDE_W-1:0] db_q;
    logic [SIDE_W-1:0] db_r;
    t_ctx              db_ctx;

    ttr_div u_div_align_w (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (d3_v),
        .i_dividend ({{SIDE_W{1'b0}}, c3_ctx.w}),
        .i_divisor  (SIDE_W'(r_bw)),
        .i_ctx      (c3_ctx),
        .o_valid    (da_v),
        .o_quot     (da_q),
        .o_rem      (da_r),
        .o_ctx      (da_ctx)
    );

    ttr_div u_div_align_h (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (d3_v),
        .i_dividend ({{SIDE_W{1'b0}}, c3_ctx.h}),
        .i_divisor  (SIDE_W'(r_bh)),
        .i_ctx      (c3_ctx),
        .o_valid    (db_v),
        .o_quot     (db_q),
        .o_rem      (db_r),
        .o_ctx      (db_ctx)
    );

    // output stage: round up to block multiple with saturation
    logic                      need_w;
    logic                      need_h;
    logic [SIDE_W+BLK_W:0]     up_w;
    logic [SIDE_W+BLK_W:0]     up_h;
    logic [SIDE_W-1:0]         n_tw;
    logic [SIDE_W-1:0]         n_th;

    always_comb begin
        need_w = r_align && (r_bw != '0) && (da_r != '0);
        need_h = r_align && (r_bh != '0) && (db_r != '0);
        up_w   = (SIDE_W+BLK_W+1)'(({1'b0, da_q} + 1'b1) * r_bw);
        up_h   = (SIDE_W+BLK_W+1)'(({1'b0, db_q} + 1'b1) * r_bh);
        n_tw   = da_ctx.w;
        n_th   = db_ctx.h;
        if (need_w) begin
            n_tw = (up_w > SIDE_LIMIT) ? SIDE_W'(SIDE_LIMIT) : up_w[SIDE_W-1:0];
        end
        if (need_h) begin
            n_th = (up_h > SIDE_LIMIT) ? SIDE_W'(SIDE_LIMIT) : up_h[SIDE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_target_width  <= n_tw;
        o_target_height <= n_th;
        o_adjusted      <= need_w || need_h;
        o_divide_error  <= da_ctx.derr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r1_v   <= i_start && !o_busy;
            r2_v   <= r1_v;
            r3_v   <= d1_v;
            o_done <= da_v && db_v;
        end
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY o_done)
        else $error("result strobe missing at fixed latency");

    a_no_err_without_volume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !r_volume) |-> !o_divide_error)
        else $error("divide error outside volume mode");

    a_no_adj_without_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !r_align) |-> !o_adjusted)
        else $error("adjusted flag without alignment");

    a_align_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        da_v == db_v)
        else $error("alignment dividers out of step");

endmodule

FILE: sim/tb_texture_target_resolution.sv
`timescale 1ns / 1ps

module tb_texture_target_resolution;
    import ttr_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int LATENCY    = 64;

    typedef struct {
        logic [SIDE_W-1:0] width;
        logic [SIDE_W-1:0] height;
        logic              adjusted;
        logic              div_err;
    } t_size;

    class size_scoreboard;
        int unsigned steps;
        int unsigned min_res;
        int unsigned max_res;
        bit          volume;
        bit          align;
        int unsigned blk_w;
        int unsigned blk_h;
        t_size       pending[$];

        function new();
            steps   = 0;
            min_res = 1;
            max_res = MAX_SIDE;
            volume  = 0;
            align   = 0;
            blk_w   = 4;
            blk_h   = 4;
        endfunction

        function void set_reg(t_reg_index idx, logic [SIDE_W-1:0] val);
            case (idx)
                REG_DOWNSCALE: steps   = 32'(val[STEPS_W-1:0]);
                REG_MIN_RES:   min_res = 32'(val);
                REG_MAX_RES:   max_res = 32'(val);
                REG_VOLUME:    volume  = val[0];
                REG_ALIGN:     align   = val[0];
                REG_BLOCK_W:   blk_w   = 32'(val[BLK_W-1:0]);
                REG_BLOCK_H:   blk_h   = 32'(val[BLK_W-1:0]);
                default: ;
            endcase
        endfunction

        function int unsigned clamp_side(int unsigned v);
            if (v < min_res) return min_res;
            if (v > max_res) return max_res;
            return v;
        endfunction

        function int unsigned round_up(int unsigned v, int unsigned blk, inout bit adj);
            int unsigned r;
            if (blk == 0 || (v % blk) == 0) return v;
            adj = 1;
            r = ((v + blk - 1) / blk) * blk;
            return (r > SIDE_LIMIT) ? SIDE_LIMIT : r;
        endfunction

        function void note_request(logic [SIDE_W-1:0] ow, logic [SIDE_W-1:0] oh);
            int unsigned w;
            int unsigned h;
            int unsigned scale;
            bit          adj;
            bit          derr;
            t_size       res;
            adj  = 0;
            derr = 0;
            w = clamp_side(int'(ow) >> steps);
            h = clamp_side(int'(oh) >> steps);
            if (ow > oh)
                h = (w * oh) / ow;
            else if (ow < oh)
                w = (h * ow) / oh;
            if (volume) begin
                if (h == 0) begin
                    derr = 1;
                end else begin
                    scale = oh / h;
                    if (scale == 0)
                        derr = 1;
                    else
                        w = ow / scale;
                end
            end
            if (align) begin
                w = round_up(w, blk_w, adj);
                h = round_up(h, blk_h, adj);
            end
            res.width    = w[SIDE_W-1:0];
            res.height   = h[SIDE_W-1:0];
            res.adjusted = adj;
            res.div_err  = derr;
            pending.push_back(res);
        endfunction

        function bit check_result(t_size got, output string msg);
            t_size exp_res;
            if (pending.size() == 0) begin
                msg = $sformatf("result with none pending: w=%0d h=%0d",
                                got.width, got.height);
                return 1;
            end
            exp_res = pending.pop_front();
            if (got.width !== exp_res.width || got.height !== exp_res.height ||
                got.adjusted !== exp_res.adjusted ||
                got.div_err !== exp_res.div_err) begin
                msg = $sformatf({"mismatch: got w=%0d h=%0d adj=%0b err=%0b, ",
                                 "want w=%0d h=%0d adj=%0b err=%0b"},
                                got.width, got.height, got.adjusted, got.div_err,
                                exp_res.width, exp_res.height, exp_res.adjusted,
                                exp_res.div_err);
                return 1;
            end
            return 0;
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    logic              o_busy;
    logic [SIDE_W-1:0] i_orig_width;
    logic [SIDE_W-1:0] i_orig_height;
    logic              i_cfg_we;
    logic [2:0]        i_cfg_index;
    logic [SIDE_W-1:0] i_cfg_wdata;
    logic              o_done;
    logic [SIDE_W-1:0] o_target_width;
    logic [SIDE_W-1:0] o_target_height;
    logic              o_adjusted;
    logic              o_divide_error;

    texture_target_resolution uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_orig_width    (i_orig_width),
        .i_orig_height   (i_orig_height),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_done          (o_done),
        .o_target_width  (o_target_width),
        .o_target_height (o_target_height),
        .o_adjusted      (o_adjusted),
        .o_divide_error  (o_divide_error)
    );

    size_scoreboard sb;
    int             n_errors;
    int             idle_cycles;
    bit             no_gaps;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    task automatic report(string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // transfer monitor and watchdog
    always @(posedge i_clk) begin
        t_size got;
        string msg;
        if (i_rst_n) begin
            if (i_start && !o_busy)
                sb.note_request(i_orig_width, i_orig_height);
            if (o_done) begin
                got.width    = o_target_width;
                got.height   = o_target_height;
                got.adjusted = o_adjusted;
                got.div_err  = o_divide_error;
                if (sb.check_result(got, msg))
                    report(msg);
            end
            if ((i_start && !o_busy) || o_done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_size(int unsigned ow, int unsigned oh);
        int unsigned gap;
        i_start       <= 1'b1;
        i_orig_width  <= ow[SIDE_W-1:0];
        i_orig_height <= oh[SIDE_W-1:0];
        forever begin
            @(negedge i_clk);
            if (!o_busy) break;
        end
        @(posedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_index idx, int unsigned val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val[SIDE_W-1:0];
        @(posedge i_clk);
        sb.set_reg(idx, val[SIDE_W-1:0]);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(int unsigned steps, int unsigned mn, int unsigned mx,
                             int unsigned vol, int unsigned aln,
                             int unsigned bw, int unsigned bh);
        write_reg(REG_DOWNSCALE, steps);
        write_reg(REG_MIN_RES, mn);
        write_reg(REG_MAX_RES, mx);
        write_reg(REG_VOLUME, vol);
        write_reg(REG_ALIGN, aln);
        write_reg(REG_BLOCK_W, bw);
        write_reg(REG_BLOCK_H, bh);
        @(posedge i_clk);
    endtask

    function automatic int unsigned pick_side();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, MAX_SIDE);
        if (r < 75) return $urandom_range(1, 64);
        if (r < 90) return $urandom_range(0, SIDE_LIMIT);
        if (r < 95) return 0;
        return SIDE_LIMIT;
    endfunction

    task automatic random_phase(int unsigned n);
        int unsigned ow;
        repeat (n) begin
            ow = pick_side();
            if ($urandom_range(0, 9) == 0)
                send_size(ow, ow);
            else
                send_size(ow, pick_side());
        end
        drain();
    endtask

    initial begin
        sb            = new();
        n_errors      = 0;
        idle_cycles   = 0;
        no_gaps       = 0;
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_orig_width  = '0;
        i_orig_height = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_wdata   = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed sizes at reset settings
        send_size(1, 1);
        send_size(MAX_SIDE, MAX_SIDE);
        send_size(SIDE_LIMIT, 1);
        send_size(1, SIDE_LIMIT);
        send_size(0, 0);
        send_size(0, 5);
        send_size(5, 0);
        send_size(SIDE_LIMIT, SIDE_LIMIT);
        send_size(1000, 500);
        send_size(500, 1000);
        drain();

        // volume, alignment, zero block, inverted bounds
        write_all(2, 300, 100, 1, 1, 0, 16);
        send_size(4000, 1000);
        send_size(1000, 4000);
        send_size(100, 3000);
        send_size(16384, 3);
        send_size(7, 7);
        drain();
        write_all(15, 0, SIDE_LIMIT, 1, 1, 31, 31);
        send_size(SIDE_LIMIT, SIDE_LIMIT);
        send_size(SIDE_LIMIT, 1);
        send_size(1, 2);
        drain();
        write_all(0, 32760, SIDE_LIMIT, 0, 1, 31, 17);
        send_size(SIDE_LIMIT, 32761);
        send_size(32761, SIDE_LIMIT);
        drain();
        write_all(0, 1, 8, 1, 0, 4, 4);
        send_size(30000, 2);
        send_size(2, 30000);
        drain();

        // random settings, extremes among them
        for (int ph = 0; ph < 9; ph++) begin
            no_gaps = (ph % 3 == 2);
            case (ph)
                0: write_all(0, 1, MAX_SIDE, 1, 1, 4, 4);
                1: write_all(14, 1, 16384, 1, 1, 1, 16);
                2: write_all(0, 0, 0, 1, 1, 0, 0);
                default: write_all($urandom_range(0, 15),
                                   ($urandom_range(0, 1) ? $urandom_range(0, 64)
                                                         : $urandom_range(0, SIDE_LIMIT)),
                                   ($urandom_range(0, 1) ? $urandom_range(0, SIDE_LIMIT)
                                                         : MAX_SIDE),
                                   $urandom_range(0, 1), $urandom_range(0, 1),
                                   $urandom_range(0, 31), $urandom_range(0, 31));
            endcase
            random_phase(50);
        end

        i_start <= 1'b0;
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
